FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on aclk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_IMP_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/bga_pkg.sv
// ----------------------------------------------------------------------------
// Battery gauge package
// Widths, register indexes, type windows, divider control and the charge ROM.
// ----------------------------------------------------------------------------
package bga_pkg;

    localparam int DETECT_SAMPLES = 20;
    localparam int ADC_BITS       = 12;
    localparam int POW_TABLE_BITS = 10;

    localparam int VOLT_W     = 16;
    localparam int PCT_W      = 7;
    localparam int TYPE_W     = 3;
    localparam int SCALE_W    = 24;
    localparam int THR_W      = 16;
    localparam int RAW_W      = 12;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int PCT_LSB   = VOLT_W;
    localparam int LOW_BIT   = PCT_LSB + PCT_W;
    localparam int VALID_BIT = LOW_BIT + 1;
    localparam int TYPE_LSB  = VALID_BIT + 1;
    localparam int M_PAD_W   = M_TDATA_W - TYPE_LSB - TYPE_W;

    localparam logic [CFG_IDX_W-1:0] REG_ADC_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BATT_TYPE = 2'd2;

    localparam logic [TYPE_W-1:0] T_USB     = 3'd0;
    localparam logic [TYPE_W-1:0] T_NIMH    = 3'd1;
    localparam logic [TYPE_W-1:0] T_LITHIUM = 3'd2;
    localparam logic [TYPE_W-1:0] T_LIION   = 3'd3;
    localparam logic [TYPE_W-1:0] T_LIFEPO4 = 3'd4;

    localparam logic [SCALE_W-1:0] SCALE_RST = '0;
    localparam logic [THR_W-1:0]   THR_RST   = 16'd3600;

    localparam logic [PCT_W-1:0]  PCT_MAX   = 7'd100;
    localparam logic [VOLT_W:0]   MARGIN_MV = 17'd500;
    localparam logic [VOLT_W-1:0] FLOOR_MV  = 16'd500;

    localparam int MUL_W    = 24;
    localparam int SUM_W    = VOLT_W + $clog2(DETECT_SAMPLES);
    localparam int SQ_W     = 2 * VOLT_W + $clog2(DETECT_SAMPLES);
    localparam int SPREAD_W = 2 * SUM_W;
    localparam int CNT_W    = $clog2(DETECT_SAMPLES + 1);

    localparam logic [SUM_W-1:0] MEAN_2000 = SUM_W'(2000 * DETECT_SAMPLES);
    localparam logic [SUM_W-1:0] MEAN_3700 = SUM_W'(3700 * DETECT_SAMPLES);
    localparam logic [SUM_W-1:0] MEAN_4500 = SUM_W'(4500 * DETECT_SAMPLES);
    localparam logic [SUM_W-1:0] MEAN_4750 = SUM_W'(4750 * DETECT_SAMPLES);
    localparam logic [SUM_W-1:0] MEAN_5250 = SUM_W'(5250 * DETECT_SAMPLES);
    localparam logic [SUM_W-1:0] MEAN_5500 = SUM_W'(5500 * DETECT_SAMPLES);
    localparam logic [SUM_W-1:0] MEAN_6500 = SUM_W'(6500 * DETECT_SAMPLES);
    localparam logic [SPREAD_W-1:0] VAR_LIMIT =
        SPREAD_W'(10000 * DETECT_SAMPLES * DETECT_SAMPLES);

    localparam int SPAN_W    = 12;
    localparam int PCT_SHIFT = 7;
    localparam int NUM_W     = SPAN_W + PCT_SHIFT;
    localparam int DIV_QW    = (POW_TABLE_BITS > PCT_SHIFT) ? POW_TABLE_BITS : PCT_SHIFT;
    localparam int STEP_W    = $clog2(DIV_QW + 1);

    localparam int POW_ROM_DEPTH = 1 << POW_TABLE_BITS;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef logic [POW_ROM_DEPTH-1:0][PCT_W-1:0] pow_rom_t;

    function automatic logic [VOLT_W-1:0] win_min(input logic [TYPE_W-1:0] t);
        logic [VOLT_W-1:0] r;
        case (t)
            T_USB:     r = 16'd4800;
            T_NIMH:    r = 16'd4000;
            T_LITHIUM: r = 16'd4000;
            T_LIION:   r = 16'd3000;
            default:   r = 16'd2500;
        endcase
        return r;
    endfunction

    function automatic logic [VOLT_W-1:0] win_max(input logic [TYPE_W-1:0] t);
        logic [VOLT_W-1:0] r;
        case (t)
            T_USB:     r = 16'd5200;
            T_NIMH:    r = 16'd5400;
            T_LITHIUM: r = 16'd6400;
            T_LIION:   r = 16'd4200;
            default:   r = 16'd3650;
        endcase
        return r;
    endfunction

    // entry i: largest p <= 100 with (p/100)^5 <= (i/depth)^4
    function automatic pow_rom_t build_pow_rom();
        pow_rom_t    rom;
        logic [95:0] m4;
        logic [95:0] i4;
        logic [95:0] rhs;
        logic [95:0] q;
        logic [95:0] q5;
        int unsigned p;
        logic        stop;
        rom = '0;
        p   = 0;
        m4  = 96'd1 << (4 * POW_TABLE_BITS);
        for (int i = 0; i < POW_ROM_DEPTH; i++) begin
            i4   = 96'(i) * 96'(i) * 96'(i) * 96'(i);
            rhs  = i4 * 96'd10000000000;
            stop = 1'b0;
            while (!stop) begin
                if (p >= 100) begin
                    stop = 1'b1;
                end else begin
                    q  = 96'(p + 1);
                    q5 = q * q * q * q * q;
                    if (q5 * m4 > rhs) begin
                        stop = 1'b1;
                    end else begin
                        p = p + 1;
                    end
                end
            end
            rom[i] = PCT_W'(p);
        end
        return rom;
    endfunction

endpackage

FILE: sv/bga_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Registered unsigned multiplier used for scaling, squares and the sum square.
// ----------------------------------------------------------------------------
module bga_mul (
    input  logic                           aclk,
    input  logic [bga_pkg::MUL_W-1:0]      op_a,
    input  logic [bga_pkg::MUL_W-1:0]      op_b,
    output logic [2*bga_pkg::MUL_W-1:0]    product
);
    import bga_pkg::*;

    logic [2*MUL_W-1:0] product_reg;

    always_ff @(posedge aclk) begin
        product_reg <= (2*MUL_W)'(op_a) * (2*MUL_W)'(op_b);
    end

    assign product = product_reg;

endmodule

FILE: sv/bga_div.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring divider, one quotient bit per cycle, remainder preloaded.
// ----------------------------------------------------------------------------
module bga_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bga_pkg::div_ctrl_t            ctrl,
    input  logic [bga_pkg::SPAN_W-1:0]    rem_init,
    input  logic [bga_pkg::DIV_QW-1:0]    num_lo,
    input  logic [bga_pkg::SPAN_W-1:0]    divisor,
    output bga_pkg::div_stat_t            stat,
    output logic [bga_pkg::DIV_QW-1:0]    quotient
);
    import bga_pkg::*;

    logic [SPAN_W-1:0] rem_reg, rem_next;
    logic [DIV_QW-1:0] shf_reg, shf_next;
    logic [DIV_QW-1:0] quo_reg, quo_next;
    logic [SPAN_W-1:0] dvs_reg, dvs_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [SPAN_W:0]   trial;
    logic              fits;

    assign trial = {rem_reg, shf_reg[DIV_QW-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        shf_next  = shf_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (ctrl.start) begin
            rem_next = rem_init;
            shf_next = num_lo;
            quo_next = '0;
            dvs_next = divisor;
            cnt_next = ctrl.steps;
        end else if (cnt_reg != '0) begin
            rem_next  = fits ? SPAN_W'(trial - {1'b0, dvs_reg}) : SPAN_W'(trial);
            shf_next  = shf_reg << 1;
            quo_next  = {quo_reg[DIV_QW-2:0], fits};
            cnt_next  = cnt_reg - STEP_W'(1);
            done_next = (cnt_reg == STEP_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        shf_reg <= shf_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = cnt_reg != '0;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

FILE: sv/bga_rom.sv
// ----------------------------------------------------------------------------
// Charge curve ROM
// NiMH 0.8-power charge table with registered read.
// ----------------------------------------------------------------------------
module bga_rom (
    input  logic                                aclk,
    input  logic [bga_pkg::POW_TABLE_BITS-1:0]  addr,
    output logic [bga_pkg::PCT_W-1:0]           data
);
    import bga_pkg::*;

    localparam pow_rom_t POW_ROM = build_pow_rom();

    logic [PCT_W-1:0] data_reg;

    always_ff @(posedge aclk) begin
        data_reg <= POW_ROM[addr];
    end

    assign data = data_reg;

endmodule

FILE: sv/battery_gauge_autodetect.sv
// From accept: S_SCALE, S_VOLT, S_PREP, then S_EMIT when charge is flat (usb, at or past a
// window edge). Linear charge adds 7 divider steps in S_DIV; the NiMH curve adds the divider
// and the ROM read (S_DIV, S_ROM, S_LOOK). A detection sample passes S_SCALE, S_VOLT, S_SQR
// and S_ACC, the last one also S_MSQ and S_CLASS. Samples are taken only in S_IDLE, one item
// at a time; S_EMIT waits while a held reading waits on m_tready. Reset: synchronous
// active-low aresetn resets control and config registers, clears detection; no clearing pass.
// ----------------------------------------------------------------------------
// Battery gauge with pack auto-detect
// Scales raw samples to mV, detects the pack type, reports charge and flags.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module battery_gauge_autodetect (
    input  logic                              aclk,
    input  logic                              aresetn,
    // cfg_data: register value, low bits used
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bga_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bga_pkg::CFG_DATA_W-1:0]    cfg_data,
    // s_tdata: [11:0] raw_sample, [15:12] zero
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bga_pkg::S_TDATA_W-1:0]     s_tdata,
    // m_tdata: [15:0] voltage_mv, [22:16] charge_percent, [23] is_low,
    //          [24] is_valid, [27:25] active_type, [31:28] zero
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bga_pkg::M_TDATA_W-1:0]     m_tdata
);
    import bga_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_SCALE = 12'b000000000010,
        S_VOLT  = 12'b000000000100,
        S_SQR   = 12'b000000001000,
        S_ACC   = 12'b000000010000,
        S_MSQ   = 12'b000000100000,
        S_CLASS = 12'b000001000000,
        S_PREP  = 12'b000010000000,
        S_DIV   = 12'b000100000000,
        S_ROM   = 12'b001000000000,
        S_LOOK  = 12'b010000000000,
        S_EMIT  = 12'b100000000000
    } state_t;

    state_t               state_reg, state_next;
    logic [SCALE_W-1:0]   scale_reg, scale_next;
    logic [THR_W-1:0]     thr_reg, thr_next;
    logic [TYPE_W-1:0]    btype_reg, btype_next;
    logic                 det_done_reg, det_done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [SQ_W-1:0]      sq_reg, sq_next;
    logic [TYPE_W-1:0]    det_reg, det_next;
    logic                 m_tvalid_reg, m_tvalid_next;

    logic [ADC_BITS-1:0]  raw_reg, raw_next;
    logic [VOLT_W-1:0]    v_reg, v_next;
    logic [TYPE_W-1:0]    t_reg, t_next;
    logic [PCT_W-1:0]     pct_reg, pct_next;
    logic                 pow_reg, pow_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [MUL_W-1:0]     mul_a, mul_b;
    logic [2*MUL_W-1:0]   product;
    logic [VOLT_W-1:0]    v_sat;
    logic [TYPE_W-1:0]    eff_type;
    logic [SPREAD_W-1:0]  nsq, spread;
    logic [TYPE_W-1:0]    class_type;

    logic [VOLT_W-1:0]    lo_mv, hi_mv;
    logic [SPAN_W-1:0]    span, diff;
    logic [NUM_W-1:0]     num;
    logic                 is_low, is_valid;

    div_ctrl_t            div_ctrl;
    div_stat_t            div_stat;
    logic [SPAN_W-1:0]    div_rem;
    logic [DIV_QW-1:0]    div_lo;
    logic [DIV_QW-1:0]    quotient;
    logic [PCT_W-1:0]     rom_data;

    bga_mul u_mul (
        .aclk    (aclk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (product)
    );

    bga_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .rem_init (div_rem),
        .num_lo   (div_lo),
        .divisor  (span),
        .stat     (div_stat),
        .quotient (quotient)
    );

    bga_rom u_rom (
        .aclk (aclk),
        .addr (quotient[POW_TABLE_BITS-1:0]),
        .data (rom_data)
    );

    always_comb begin
        case (state_reg)
            S_SQR: begin
                mul_a = MUL_W'(v_reg);
                mul_b = MUL_W'(v_reg);
            end
            S_MSQ: begin
                mul_a = MUL_W'(sum_reg);
                mul_b = MUL_W'(sum_reg);
            end
            default: begin
                mul_a = MUL_W'(raw_reg);
                mul_b = MUL_W'(scale_reg);
            end
        endcase
    end

    assign v_sat    = (product[2*MUL_W-1:32] != '0) ? '1 : product[31:16];
    assign eff_type = (btype_reg > T_LIFEPO4) ? T_LIFEPO4 : btype_reg;

    // detection: mean window by sum, variance as N*sumsq - sum^2
    assign nsq    = SPREAD_W'(sq_reg) * SPREAD_W'(DETECT_SAMPLES);
    assign spread = nsq - product[SPREAD_W-1:0];

    always_comb begin
        if (sum_reg >= MEAN_4750 && sum_reg <= MEAN_5250) begin
            class_type = (spread < VAR_LIMIT) ? T_USB : T_NIMH;
        end else if (sum_reg >= MEAN_2000 && sum_reg <= MEAN_3700) begin
            class_type = T_LIFEPO4;
        end else if (sum_reg > MEAN_3700 && sum_reg <= MEAN_4500) begin
            class_type = T_LIION;
        end else if (sum_reg > MEAN_4500 && sum_reg <= MEAN_5500) begin
            class_type = T_NIMH;
        end else if (sum_reg > MEAN_5500 && sum_reg <= MEAN_6500) begin
            class_type = T_LITHIUM;
        end else begin
            class_type = T_NIMH;
        end
    end

    assign lo_mv = win_min(t_reg);
    assign hi_mv = win_max(t_reg);
    assign span  = SPAN_W'(hi_mv - lo_mv);
    assign diff  = SPAN_W'(v_reg - lo_mv);
    assign num   = NUM_W'(diff) * NUM_W'(PCT_MAX);

    assign is_low   = (v_reg < thr_reg) && (v_reg > FLOOR_MV);
    assign is_valid = ({1'b0, v_reg} + MARGIN_MV >= {1'b0, lo_mv})
                   && ({1'b0, v_reg} <= {1'b0, hi_mv} + MARGIN_MV);

    always_comb begin
        state_next    = state_reg;
        scale_next    = scale_reg;
        thr_next      = thr_reg;
        btype_next    = btype_reg;
        det_done_next = det_done_reg;
        cnt_next      = cnt_reg;
        sum_next      = sum_reg;
        sq_next       = sq_reg;
        det_next      = det_reg;
        m_tvalid_next = m_tvalid_reg;
        raw_next      = raw_reg;
        v_next        = v_reg;
        t_next        = t_reg;
        pct_next      = pct_reg;
        pow_next      = pow_reg;
        m_tdata_next  = m_tdata_reg;
        div_ctrl      = '0;
        div_rem       = diff;
        div_lo        = '0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    raw_next   = s_tdata[ADC_BITS-1:0];
                    state_next = S_SCALE;
                end
            end
            S_SCALE: begin
                state_next = S_VOLT;
            end
            S_VOLT: begin
                v_next = v_sat;
                if (eff_type == T_NIMH && !det_done_reg) begin
                    state_next = S_SQR;
                end else begin
                    t_next     = (eff_type == T_NIMH) ? det_reg : eff_type;
                    state_next = S_PREP;
                end
            end
            S_SQR: begin
                sum_next   = sum_reg + SUM_W'(v_reg);
                state_next = S_ACC;
            end
            S_ACC: begin
                sq_next  = sq_reg + SQ_W'(product[2*VOLT_W-1:0]);
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DETECT_SAMPLES - 1)) begin
                    state_next = S_MSQ;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_MSQ: begin
                state_next = S_CLASS;
            end
            S_CLASS: begin
                det_next      = class_type;
                det_done_next = 1'b1;
                cnt_next      = '0;
                state_next    = S_IDLE;
            end
            S_PREP: begin
                if (t_reg == T_USB || v_reg >= hi_mv) begin
                    pct_next   = PCT_MAX;
                    state_next = S_EMIT;
                end else if (v_reg <= lo_mv) begin
                    pct_next   = '0;
                    state_next = S_EMIT;
                end else begin
                    div_ctrl.start = 1'b1;
                    pow_next       = (t_reg == T_NIMH);
                    if (t_reg == T_NIMH) begin
                        div_ctrl.steps = STEP_W'(POW_TABLE_BITS);
                    end else begin
                        div_ctrl.steps = STEP_W'(PCT_SHIFT);
                        div_rem        = num[NUM_W-1:PCT_SHIFT];
                        div_lo         = DIV_QW'(num[PCT_SHIFT-1:0]) << (DIV_QW - PCT_SHIFT);
                    end
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    if (pow_reg) begin
                        state_next = S_ROM;
                    end else begin
                        pct_next   = quotient[PCT_W-1:0];
                        state_next = S_EMIT;
                    end
                end
            end
            S_ROM: begin
                state_next = S_LOOK;
            end
            S_LOOK: begin
                pct_next   = rom_data;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = {{M_PAD_W{1'b0}}, t_reg, is_valid, is_low, pct_reg, v_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid) begin
            case (cfg_index)
                REG_ADC_SCALE: scale_next = cfg_data[SCALE_W-1:0];
                REG_LOW_THR:   thr_next   = cfg_data[THR_W-1:0];
                REG_BATT_TYPE: begin
                    btype_next    = cfg_data[TYPE_W-1:0];
                    det_done_next = 1'b0;
                    cnt_next      = '0;
                    sum_next      = '0;
                    sq_next       = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            scale_reg    <= SCALE_RST;
            thr_reg      <= THR_RST;
            btype_reg    <= T_NIMH;
            det_done_reg <= 1'b0;
            cnt_reg      <= '0;
            sum_reg      <= '0;
            sq_reg       <= '0;
            det_reg      <= T_NIMH;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            scale_reg    <= scale_next;
            thr_reg      <= thr_next;
            btype_reg    <= btype_next;
            det_done_reg <= det_done_next;
            cnt_reg      <= cnt_next;
            sum_reg      <= sum_next;
            sq_reg       <= sq_next;
            det_reg      <= det_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        raw_reg     <= raw_next;
        v_reg       <= v_next;
        t_reg       <= t_next;
        pct_reg     <= pct_next;
        pow_reg     <= pow_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    `ASSERT_IMP(a_accept_div_idle, s_tvalid && s_tready, !div_stat.busy, "input taken while divider busy")
    `ASSERT_IMP(a_pct_range, m_tvalid, m_tdata[LOW_BIT-1:PCT_LSB] <= PCT_MAX, "charge above 100")
    `ASSERT_IMP(a_low_floor, m_tvalid && m_tdata[LOW_BIT], m_tdata[VOLT_W-1:0] > FLOOR_MV, "low flag at floor")
    `ASSERT_IMP_NEXT(a_detect_close, state_reg == S_CLASS && !(cfg_valid && cfg_index == REG_BATT_TYPE), det_done_reg && cnt_reg == '0, "detection did not close")

endmodule
